// ===== hw/rtl/text_console_cursor_scroll_macros.svh =====
// Assertion macros used by the console checker file.
`ifndef TEXT_CONSOLE_CURSOR_SCROLL_MACROS_SVH
`define TEXT_CONSOLE_CURSOR_SCROLL_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during rst.
`define TCC_ASSERT_IMP(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (con)) \
    else $error("text console check failed");

// Next-cycle implication, sampled on clk and disabled during rst.
`define TCC_ASSERT_NXT(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (con)) \
    else $error("text console check failed");

`endif

// ===== hw/rtl/tcc_pkg.sv =====
// Types, constants and helper functions of the text console engine.
`default_nettype none

package tcc_pkg;

  localparam int MAX_COLS = 80;
  localparam int MAX_ROWS = 25;
  localparam int CELLS    = MAX_COLS * MAX_ROWS;
  localparam int ADDR_W   = $clog2(CELLS);
  localparam int ROW_W    = 5;
  localparam int COL_W    = 7;

  localparam logic [7:0]  CH_BS    = 8'd8;
  localparam logic [7:0]  CH_TAB   = 8'd9;
  localparam logic [7:0]  CH_LF    = 8'd10;
  localparam logic [7:0]  CH_CR    = 8'd13;
  localparam logic [7:0]  CH_SPACE = 8'd32;
  localparam logic [15:0] RESET_CELL = 16'h0720;

  localparam logic [1:0] REG_TEXT_COLOR  = 2'd0;
  localparam logic [1:0] REG_TAB_WIDTH   = 2'd1;
  localparam logic [1:0] REG_COLS_IN_USE = 2'd2;
  localparam logic [1:0] REG_ROWS_IN_USE = 2'd3;

  localparam logic CMD_PUT  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef struct packed {
    logic             cmd;
    logic [7:0]       char_code;
    logic [ROW_W-1:0] cell_row;
    logic [COL_W-1:0] cell_col;
  } tcc_in_t;

  typedef struct packed {
    logic [15:0]      cell_value;
    logic [ROW_W-1:0] cursor_row;
    logic [COL_W-1:0] cursor_col;
    logic             scrolled;
  } tcc_out_t;

  function automatic logic [ADDR_W-1:0] cell_addr(logic [ROW_W-1:0] row,
                                                  logic [COL_W-1:0] col);
    cell_addr = ADDR_W'(row) * ADDR_W'(MAX_COLS) + ADDR_W'(col);
  endfunction

  // A zero count acts as one, a count above the maximum as the maximum.
  function automatic logic [COL_W-1:0] eff_cols(logic [COL_W-1:0] v);
    if (v == '0) begin
      eff_cols = COL_W'(1);
    end else if (32'(v) > MAX_COLS) begin
      eff_cols = COL_W'(MAX_COLS);
    end else begin
      eff_cols = v;
    end
  endfunction

  function automatic logic [ROW_W-1:0] eff_rows(logic [ROW_W-1:0] v);
    if (v == '0) begin
      eff_rows = ROW_W'(1);
    end else if (32'(v) > MAX_ROWS) begin
      eff_rows = ROW_W'(MAX_ROWS);
    end else begin
      eff_rows = v;
    end
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/text_console_cursor_scroll.sv =====
// Top level of the text console engine: cursor control, scrolling and cell reads.
//
// Usage: present an item on item and raise start; it is taken at a clock edge
// where busy is low. Every item yields one result on result, marked by done for
// exactly one cycle; the receiver cannot stall it.
// A put that only moves the cursor or writes one character returns its result
// in the cycle after it is taken, and busy stays low, so puts can go one per
// cycle. A read waits, busy high, for the registered read data of the screen
// memory, and its result is registered from that data.
// A put that scrolls walks the screen memory through its one read port and one
// write port, reading and then writing each moved cell and then blanking the
// bottom row, busy high throughout.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once and
// clamp the cursor into a shrunk area; issue them only while no item is open.
// After rst the block runs a clearing pass that fills all 2000 cells with a
// grey-on-black space, one cell a cycle; busy is high until the pass is done.
`default_nettype none

module text_console_cursor_scroll (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire tcc_pkg::tcc_in_t  item,
  output logic                   done,
  output tcc_pkg::tcc_out_t      result,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [7:0]        cfg_data
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RD_WAIT,
    S_SC_RD,
    S_SC_WR,
    S_BLANK
  } state_t;

  state_t state;

  logic [7:0]                 text_color;
  logic [3:0]                 tab_width;
  logic [tcc_pkg::COL_W-1:0]  cols_in_use;
  logic [tcc_pkg::ROW_W-1:0]  rows_in_use;
  logic [tcc_pkg::ROW_W-1:0]  cur_row;
  logic [tcc_pkg::COL_W-1:0]  cur_col;
  logic [tcc_pkg::ADDR_W-1:0] clr_addr;
  logic [tcc_pkg::ROW_W-1:0]  sc_row;
  logic [tcc_pkg::COL_W-1:0]  sc_col;
  logic                       rd_ok;

  logic [tcc_pkg::COL_W-1:0]  ec;
  logic [tcc_pkg::ROW_W-1:0]  er;
  logic [tcc_pkg::COL_W-1:0]  new_col;
  logic [tcc_pkg::ROW_W-1:0]  new_row;
  logic                       wr_char;
  logic                       do_scroll;
  logic                       rd_in_range;
  logic                       accept;

  logic                       ram_we;
  logic [tcc_pkg::ADDR_W-1:0] ram_waddr;
  logic [15:0]                ram_wdata;
  logic [tcc_pkg::ADDR_W-1:0] ram_raddr;
  logic [15:0]                ram_rdata;

  logic [tcc_pkg::COL_W-1:0]  cfg_cols_eff;
  logic [tcc_pkg::ROW_W-1:0]  cfg_rows_eff;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign ec     = tcc_pkg::eff_cols(cols_in_use);
  assign er     = tcc_pkg::eff_rows(rows_in_use);

  assign cfg_cols_eff = tcc_pkg::eff_cols(cfg_data[tcc_pkg::COL_W-1:0]);
  assign cfg_rows_eff = tcc_pkg::eff_rows(cfg_data[tcc_pkg::ROW_W-1:0]);

  assign rd_in_range = (32'(item.cell_row) < tcc_pkg::MAX_ROWS) &&
                       (32'(item.cell_col) < tcc_pkg::MAX_COLS);

  // Cursor after a put, including the wrap to the next row and the scroll.
  always_comb begin
    new_col   = cur_col;
    new_row   = cur_row;
    wr_char   = 1'b0;
    case (item.char_code)
      tcc_pkg::CH_LF: begin
        new_col = '0;
        new_row = cur_row + 1'b1;
      end
      tcc_pkg::CH_CR: begin
        new_col = '0;
      end
      tcc_pkg::CH_BS: begin
        if (cur_col != '0) begin
          new_col = cur_col - 1'b1;
        end
      end
      tcc_pkg::CH_TAB: begin
        new_col = cur_col + tcc_pkg::COL_W'(tab_width);
      end
      default: begin
        new_col = cur_col + 1'b1;
        wr_char = 1'b1;
      end
    endcase
    if (new_col >= ec) begin
      new_col = '0;
      new_row = new_row + 1'b1;
    end
    do_scroll = (new_row >= er);
    if (do_scroll) begin
      new_row = er - 1'b1;
      new_col = '0;
    end
  end

  // Screen memory port selection by sequencer state.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = tcc_pkg::cell_addr(cur_row, cur_col);
    ram_wdata = {text_color, item.char_code};
    ram_raddr = rd_in_range ? tcc_pkg::cell_addr(item.cell_row, item.cell_col) : '0;
    unique case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = tcc_pkg::RESET_CELL;
      end
      S_IDLE: begin
        ram_we = accept && (item.cmd == tcc_pkg::CMD_PUT) && wr_char;
      end
      S_RD_WAIT: begin
      end
      S_SC_RD: begin
        ram_raddr = tcc_pkg::cell_addr(sc_row + 1'b1, sc_col);
      end
      S_SC_WR: begin
        ram_we    = 1'b1;
        ram_waddr = tcc_pkg::cell_addr(sc_row, sc_col);
        ram_wdata = ram_rdata;
      end
      S_BLANK: begin
        ram_we    = 1'b1;
        ram_waddr = tcc_pkg::cell_addr(er - 1'b1, sc_col);
        ram_wdata = {text_color, tcc_pkg::CH_SPACE};
      end
      default: begin
      end
    endcase
  end

  tcc_screen_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      done        <= 1'b0;
      text_color  <= 8'd7;
      tab_width   <= 4'd2;
      cols_in_use <= tcc_pkg::COL_W'(tcc_pkg::MAX_COLS);
      rows_in_use <= tcc_pkg::ROW_W'(tcc_pkg::MAX_ROWS);
      cur_row     <= '0;
      cur_col     <= '0;
      clr_addr    <= '0;
      sc_row      <= '0;
      sc_col      <= '0;
      rd_ok       <= 1'b0;
    end else begin
      done <= 1'b0;

      if (cfg_we) begin
        unique case (cfg_index)
          tcc_pkg::REG_TEXT_COLOR: text_color <= cfg_data;
          tcc_pkg::REG_TAB_WIDTH:  tab_width  <= cfg_data[3:0];
          tcc_pkg::REG_COLS_IN_USE: begin
            cols_in_use <= cfg_data[tcc_pkg::COL_W-1:0];
            if (cur_col >= cfg_cols_eff) begin
              cur_col <= cfg_cols_eff - 1'b1;
            end
          end
          tcc_pkg::REG_ROWS_IN_USE: begin
            rows_in_use <= cfg_data[tcc_pkg::ROW_W-1:0];
            if (cur_row >= cfg_rows_eff) begin
              cur_row <= cfg_rows_eff - 1'b1;
            end
          end
          default: begin
          end
        endcase
      end

      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (32'(clr_addr) == tcc_pkg::CELLS - 1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            if (item.cmd == tcc_pkg::CMD_READ) begin
              rd_ok <= rd_in_range;
              state <= S_RD_WAIT;
            end else begin
              cur_row <= new_row;
              cur_col <= new_col;
              sc_row  <= '0;
              sc_col  <= '0;
              if (do_scroll) begin
                // A one-row screen has nothing to move, only the blanking.
                state <= (er == tcc_pkg::ROW_W'(1)) ? S_BLANK : S_SC_RD;
              end else begin
                done              <= 1'b1;
                result.cell_value <= '0;
                result.cursor_row <= new_row;
                result.cursor_col <= new_col;
                result.scrolled   <= 1'b0;
              end
            end
          end
        end
        S_RD_WAIT: begin
          done              <= 1'b1;
          result.cell_value <= rd_ok ? ram_rdata : '0;
          result.cursor_row <= cur_row;
          result.cursor_col <= cur_col;
          result.scrolled   <= 1'b0;
          state             <= S_IDLE;
        end
        S_SC_RD: begin
          state <= S_SC_WR;
        end
        S_SC_WR: begin
          if (sc_col == ec - 1'b1) begin
            sc_col <= '0;
            if (sc_row == er - 2'd2) begin
              state <= S_BLANK;
            end else begin
              sc_row <= sc_row + 1'b1;
              state  <= S_SC_RD;
            end
          end else begin
            sc_col <= sc_col + 1'b1;
            state  <= S_SC_RD;
          end
        end
        S_BLANK: begin
          sc_col <= sc_col + 1'b1;
          if (sc_col == ec - 1'b1) begin
            done              <= 1'b1;
            result.cell_value <= '0;
            result.cursor_row <= cur_row;
            result.cursor_col <= cur_col;
            result.scrolled   <= 1'b1;
            state             <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tcc_screen_ram.sv =====
// Screen cell memory: one write port, one read port with registered data.
`default_nettype none

module tcc_screen_ram (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [tcc_pkg::ADDR_W-1:0] waddr,
  input  wire logic [15:0]                wdata,
  input  wire logic [tcc_pkg::ADDR_W-1:0] raddr,
  output logic      [15:0]                rdata
);

  logic [15:0] mem [tcc_pkg::CELLS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tcc_checker.sv =====
// Port-level checks on the text console engine and their binding to the top level.
`default_nettype none
`include "text_console_cursor_scroll_macros.svh"

module tcc_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              start,
  input wire logic              busy,
  input wire tcc_pkg::tcc_in_t  item,
  input wire logic              done,
  input wire tcc_pkg::tcc_out_t result
);

  // A put either finishes in the next cycle or holds the block for a scroll.
  `TCC_ASSERT_NXT(a_put_next, start && !busy && item.cmd == tcc_pkg::CMD_PUT, done || busy)

  // A read always waits for the memory data, with busy high and no done, in the cycle after it is taken.
  `TCC_ASSERT_NXT(a_read_wait, start && !busy && item.cmd == tcc_pkg::CMD_READ, busy && !done)

  `TCC_ASSERT_IMP(a_cursor_range, done, (32'(result.cursor_row) < tcc_pkg::MAX_ROWS) && (32'(result.cursor_col) < tcc_pkg::MAX_COLS))

  // After a scroll the cursor sits at the start of the bottom row; the check covers its column and a zero cell value.
  `TCC_ASSERT_IMP(a_scroll_shape, done && result.scrolled, result.cursor_col == '0 && result.cell_value == '0)

endmodule

bind text_console_cursor_scroll tcc_checker u_tcc_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .item   (item),
  .done   (done),
  .result (result)
);

`default_nettype wire
